// File: rtl/pfdrc_pkg.sv
// Shared types and constants of the packet FIFO with duplicate filter and range counter.
package pfdrc_pkg;

  localparam int unsigned DepthDef  = 64;
  localparam int unsigned CapW      = 7;
  localparam int unsigned CountW    = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;
  localparam int unsigned CountSat  = 127;

  typedef enum logic [1:0] {
    ReqAdd   = 2'd0,
    ReqFwd   = 2'd1,
    ReqCount = 2'd2
  } req_e;

  typedef struct packed {
    logic [15:0] src;
    logic [15:0] dst;
    logic [31:0] ts;
  } pkt_t;

  localparam int unsigned PktW = $bits(pkt_t);

endpackage

// File: rtl/packet_fifo_dedup_range_count_core.sv
// Top level of the packet FIFO with duplicate filter and range counter.
//
// Requests arrive on the input channel (in_valid_i / in_stall_o) and each one
// yields exactly one result transaction on the output channel (out_valid_o /
// out_stall_i). A request is an add, a forward of the oldest packet, or a count
// of stored packets with a given destination and a timestamp inside an
// inclusive window. Packets live in one RAM that is read one entry per cycle.
// An add or a count walks every stored packet through the shared compare unit;
// a forward reads the oldest entry only, and no entry is read when the FIFO is
// empty. The RAM read port sets the pace of the walk: one entry per cycle. The
// block takes one request at a time, and a new request is accepted in the cycle
// after the result has been registered, even while that result is still
// stalled. If the receiver stalls, the result register holds its value and a
// finished request waits before updating the FIFO until the register is free.
// The user must write the capacity register through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block itself does not enforce this. Reset empties
// the FIFO and sets the capacity to 64; the RAM needs no clearing, since only
// occupied entries are ever read.
module packet_fifo_dedup_range_count_core import pfdrc_pkg::*; #(
  parameter int unsigned DEPTH = DepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CapW-1:0]   cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [15:0]       source_i,
  input  logic [15:0]       destination_i,
  input  logic [31:0]       timestamp_i,
  input  logic [31:0]       start_time_i,
  input  logic [31:0]       end_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              accepted_o,
  output logic              fwd_valid_o,
  output logic [15:0]       out_source_o,
  output logic [15:0]       out_destination_o,
  output logic [31:0]       out_timestamp_o,
  output logic [CountW-1:0] match_count_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned OccW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (OccW > CapW) ? OccW : CapW;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StScan = 3'b010,
    StDone = 3'b100
  } state_e;

  state_e state_d, state_q;

  logic [CapW-1:0] cap_q;
  logic [PtrW-1:0] head_d, head_q, tail_d, tail_q, rptr_d, rptr_q;
  logic [OccW-1:0] occ_d, occ_q, iss_d, iss_q, len_d, len_q;
  logic            rvld_d, rvld_q;
  logic            out_valid_d, out_valid_q;

  // Request held for the duration of its processing.
  logic [1:0]  op_q;
  pkt_t        key_q;
  logic [31:0] lo_q, hi_q;

  // Result register.
  logic              acc_q, fwd_q;
  pkt_t              res_pkt_q;
  logic [CountW-1:0] cnt_res_q;

  logic              in_acc, issue, load_res, full_drop, is_dup, ram_we;
  logic [CmpW-1:0]   cap_ext, eff_cap;
  logic [OccW-1:0]   hit_cnt;
  logic [CountW-1:0] cnt_sat;
  pkt_t              rdata;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    nxt = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == StScan) && (iss_q != len_q);
  assign load_res   = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  // A zero capacity acts as one; a capacity beyond the RAM acts as its depth.
  always_comb begin
    cap_ext = CmpW'(cap_q);
    if (cap_ext == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_ext > CmpW'(DEPTH)) begin
      eff_cap = CmpW'(DEPTH);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full_drop = (CmpW'(occ_q) >= eff_cap) && (occ_q != '0);
  assign is_dup    = (hit_cnt != '0);
  assign ram_we    = load_res && (op_q == ReqAdd) && !is_dup;
  assign cnt_sat   = (CmpW'(hit_cnt) > CmpW'(CountSat)) ? CountW'(CountSat)
                                                          : CountW'(hit_cnt);

  // Sequencer: accept, stream the entries through the compare unit, then commit.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    rptr_d      = rptr_q;
    iss_d       = iss_q;
    len_d       = len_q;
    rvld_d      = issue;
    out_valid_d = out_valid_q && out_stall_i;

    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          rptr_d = head_q;
          iss_d  = '0;
          case (req_type_i) inside
            ReqAdd, ReqCount: len_d = occ_q;
            ReqFwd:           len_d = (occ_q != '0) ? OccW'(1) : '0;
            default:          len_d = '0;
          endcase
          state_d = StScan;
        end
      end
      StScan: begin
        if (issue) begin
          rptr_d = nxt(rptr_q);
          iss_d  = iss_q + 1'b1;
        end else if (!rvld_q) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (load_res) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          case (op_q)
            ReqAdd: begin
              if (!is_dup) begin
                tail_d = nxt(tail_q);
                if (full_drop) begin
                  head_d = nxt(head_q);
                end else begin
                  occ_d = occ_q + 1'b1;
                end
              end
            end
            ReqFwd: begin
              if (occ_q != '0) begin
                head_d = nxt(head_q);
                occ_d  = occ_q - 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cap_q       <= CapReset;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      rptr_q      <= '0;
      iss_q       <= '0;
      len_q       <= '0;
      rvld_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      rptr_q      <= rptr_d;
      iss_q       <= iss_d;
      len_q       <= len_d;
      rvld_q      <= rvld_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Request capture and result register; payload only, so no reset.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q      <= req_type_i;
      key_q.src <= source_i;
      key_q.dst <= destination_i;
      key_q.ts  <= timestamp_i;
      lo_q      <= start_time_i;
      hi_q      <= end_time_i;
    end
    if (load_res) begin
      acc_q     <= (op_q == ReqAdd) && !is_dup;
      fwd_q     <= (op_q == ReqFwd) && (occ_q != '0);
      res_pkt_q <= ((op_q == ReqFwd) && (occ_q != '0)) ? rdata : '0;
      cnt_res_q <= (op_q == ReqCount) ? cnt_sat : '0;
    end
  end

  pfdrc_ram #(
    .Width (PktW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (key_q),
    .re_i    (issue),
    .raddr_i (rptr_q),
    .rdata_o (rdata)
  );

  pfdrc_cmp #(
    .CntW (OccW)
  ) u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (in_acc),
    .en_i    (rvld_q),
    .op_i    (op_q),
    .key_i   (key_q),
    .lo_i    (lo_q),
    .hi_i    (hi_q),
    .entry_i (rdata),
    .count_o (hit_cnt)
  );

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = acc_q;
  assign fwd_valid_o       = fwd_q;
  assign out_source_o      = res_pkt_q.src;
  assign out_destination_o = res_pkt_q.dst;
  assign out_timestamp_o   = res_pkt_q.ts;
  assign match_count_o     = cnt_res_q;

endmodule

// File: rtl/pfdrc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pfdrc_ram import pfdrc_pkg::*; #(
  parameter int unsigned Width = PktW,
  parameter int unsigned Depth = DepthDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/pfdrc_cmp.sv
// Shared compare unit: matches one stored entry per cycle and accumulates the hits.
module pfdrc_cmp import pfdrc_pkg::*; #(
  parameter int unsigned CntW = CountW
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            clr_i,
  input  logic            en_i,
  input  logic [1:0]      op_i,
  input  pkt_t            key_i,
  input  logic [31:0]     lo_i,
  input  logic [31:0]     hi_i,
  input  pkt_t            entry_i,
  output logic [CntW-1:0] count_o
);

  logic            hit;
  logic [CntW-1:0] count_d, count_q;

  // An add looks for an exact copy; a count looks for the destination within the window.
  always_comb begin
    case (op_i)
      ReqAdd:   hit = (entry_i == key_i);
      ReqCount: hit = (entry_i.dst == key_i.dst) && (entry_i.ts >= lo_i) &&
                      (entry_i.ts <= hi_i);
      default:  hit = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (clr_i) begin
      count_d = '0;
    end else if (en_i && hit) begin
      count_d = count_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign count_o = count_q;

endmodule
